>>> src/pcaw_pkg.sv
// Shared constants and register-index codes of the PID controller with angle wrap.
package pcaw_pkg;

  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I_SCALED = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_INTEG_MIN     = 3'd3,
    CFG_INTEG_MAX     = 3'd4,
    CFG_DRIVE_MIN     = 3'd5,
    CFG_DRIVE_MAX     = 3'd6,
    CFG_ANGLE_MODE    = 3'd7
  } cfg_reg_e;

  // Number of pipeline registers from input to result, result register included
  localparam int unsigned NUM_STAGES = 8;

endpackage

>>> src/pid_controller_angle_wrap_unit.sv
// Pipelined PID controller with integrator clamp, output clamp and 360 degree wrap.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------------
//  input   | in_valid_i  | in_ready_o  | target_i, sensed_i
//  result  | out_valid_o | out_ready_i | drive_o
//  config  | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// Eight register stages from a request to its result; one request per cycle while not stalled.
// The integrator update is the only loop: one saturating add and clamp per cycle, if not stalled.
// Each stage advances when the stage after it is empty or advancing, so bubbles collapse
// and a stalled result holds only the stages behind it once they fill up.
// Reset clears all valid bits, the integrator, the previous error and measurement,
// and loads the register defaults; configuration writes are always taken.
module pid_controller_angle_wrap_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input requests
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]     target_i,
  input  logic signed [DATA_WIDTH-1:0]     sensed_i,
  // results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [DATA_WIDTH-1:0]     drive_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pcaw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DATA_WIDTH-1:0]            cfg_data_i
);
  import pcaw_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  // Extended width: holds sums of three values and the 360 degree constant
  localparam int EW = ((DATA_WIDTH > FRAC_BITS + 10) ? DATA_WIDTH : FRAC_BITS + 10) + 2;

  localparam logic signed [EW-1:0] DMAX_X   = EW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [EW-1:0] DMIN_X   = ~DMAX_X;
  localparam logic signed [EW-1:0] DEG180_X = EW'(180) << FRAC_BITS;
  localparam logic signed [EW-1:0] DEG360_X = EW'(360) << FRAC_BITS;
  localparam logic signed [EW-1:0] NEG180_X = -DEG180_X;
  localparam logic signed [PW-1:0] PMAX_X   = PW'(DMAX_X);
  localparam logic signed [PW-1:0] PMIN_X   = PW'(DMIN_X);

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [EW-1:0] ext(input logic signed [DW-1:0] v);
    return EW'(v);
  endfunction

  function automatic logic signed [DW-1:0] sat_x(input logic signed [EW-1:0] v);
    if (v > DMAX_X) begin
      return DMAX_X[DW-1:0];
    end else if (v < DMIN_X) begin
      return DMIN_X[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] wrap(input logic signed [DW-1:0] v);
    logic signed [EW-1:0] a;
    a = ext(v);
    if (a < NEG180_X) begin
      a = ext(sat_x(a + DEG360_X));
    end
    if (a > DEG180_X) begin
      return sat_x(a - DEG360_X);
    end
    return a[DW-1:0];
  endfunction

  // Rescale a full product, rounding toward minus infinity, then saturate
  function automatic logic signed [DW-1:0] rescale(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    if (s > PMAX_X) begin
      return PMAX_X[DW-1:0];
    end else if (s < PMIN_X) begin
      return PMIN_X[DW-1:0];
    end
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] v);
    if (v == DMIN_X[DW-1:0]) begin
      return DMAX_X[DW-1:0];
    end
    return -v;
  endfunction

  // Max test first, so with reversed limits a value above hi gives hi and any other value gives lo
  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DW-1:0] integ_min_q, integ_max_q, drive_min_q, drive_max_q;
  logic                 angle_mode_q;

  assign cfg_ready_o = 1'b1;

  // Write one register per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      integ_min_q  <= DMIN_X[DW-1:0];
      integ_max_q  <= DMAX_X[DW-1:0];
      drive_min_q  <= DMIN_X[DW-1:0];
      drive_max_q  <= DMAX_X[DW-1:0];
      angle_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GAIN_P:        gain_p_q     <= cfg_data_i;
        CFG_GAIN_I_SCALED: gain_i_q     <= cfg_data_i;
        CFG_GAIN_D:        gain_d_q     <= cfg_data_i;
        CFG_INTEG_MIN:     integ_min_q  <= cfg_data_i;
        CFG_INTEG_MAX:     integ_max_q  <= cfg_data_i;
        CFG_DRIVE_MIN:     drive_min_q  <= cfg_data_i;
        CFG_DRIVE_MAX:     drive_max_q  <= cfg_data_i;
        CFG_ANGLE_MODE:    angle_mode_q <= cfg_data_i[0];
        default:           angle_mode_q <= angle_mode_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Stage k of valid_q: 0 input, 1..6 work stages, 7 result
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [DW-1:0] tgt1_q, sen1_q;
  logic signed [DW-1:0] tgt2_q, sen2_q;
  logic signed [DW-1:0] err3_q, sen3_q, perr3_q, psen3_q;
  logic signed [DW-1:0] err4_q, esum4_q, dsen4_q;
  logic signed [PW-1:0] pprod5_q, iprod5_q, dprod5_q;
  logic signed [DW-1:0] prop6_q, iterm6_q, deriv6_q;
  logic signed [DW-1:0] prop7_q, deriv7_q;
  logic signed [DW-1:0] drive_q;

  logic signed [DW-1:0] last_error_q, last_sensed_q, integ_acc_q;

  logic signed [DW-1:0] tgt2_d, err3_d, integ_acc_d, drive_d;
  logic signed [DW-1:0] err_raw;
  logic signed [EW-1:0] drive_sum;
  logic                 hist_adv, integ_adv;

  assign hist_adv  = valid_q[1] && stage_en[2];
  assign integ_adv = valid_q[5] && stage_en[6];

  // Wrap the setpoint in angle mode, form the error and wrap it in angle mode
  always_comb begin
    tgt2_d  = angle_mode_q ? wrap(tgt1_q) : tgt1_q;
    err_raw = sat_x(ext(tgt2_q) - ext(sen2_q));
    err3_d  = angle_mode_q ? wrap(err_raw) : err_raw;
  end

  // Saturating integrator update, then clamp
  assign integ_acc_d = clamp(sat_x(ext(integ_acc_q) + ext(iterm6_q)), integ_min_q, integ_max_q);

  // Exact three-term sum, saturate once, then clamp
  assign drive_sum = ext(prop7_q) + ext(integ_acc_q) + ext(deriv7_q);
  assign drive_d   = clamp(sat_x(drive_sum), drive_min_q, drive_max_q);

  // Pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      tgt1_q <= target_i;
      sen1_q <= sensed_i;
    end
    if (stage_en[1]) begin
      tgt2_q <= tgt2_d;
      sen2_q <= sen1_q;
    end
    if (stage_en[2]) begin
      err3_q  <= err3_d;
      sen3_q  <= sen2_q;
      perr3_q <= last_error_q;
      psen3_q <= last_sensed_q;
    end
    if (stage_en[3]) begin
      err4_q  <= err3_q;
      esum4_q <= sat_x(ext(err3_q) + ext(perr3_q));
      dsen4_q <= sat_x(ext(sen3_q) - ext(psen3_q));
    end
    if (stage_en[4]) begin
      pprod5_q <= gain_p_q * err4_q;
      iprod5_q <= gain_i_q * esum4_q;
      dprod5_q <= gain_d_q * dsen4_q;
    end
    if (stage_en[5]) begin
      prop6_q  <= rescale(pprod5_q);
      iterm6_q <= rescale(iprod5_q);
      deriv6_q <= neg_sat(rescale(dprod5_q));
    end
    if (stage_en[6]) begin
      prop7_q  <= prop6_q;
      deriv7_q <= deriv6_q;
    end
    if (stage_en[7]) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

  // Controller state: advance once per request, in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q  <= '0;
      last_sensed_q <= '0;
      integ_acc_q   <= '0;
    end else begin
      if (hist_adv) begin
        last_error_q  <= err3_d;
        last_sensed_q <= sen2_q;
      end
      if (integ_adv) begin
        integ_acc_q <= integ_acc_d;
      end
    end
  end

`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // History registers change only when a request moves past the error stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hist_adv |=> $stable(last_error_q) && $stable(last_sensed_q))
    else $error("error history changed without a request");

  // Integrator stays inside ordered limits after an update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_adv && (integ_min_q <= integ_max_q)
    |=> (integ_acc_q <= $past(integ_max_q)) && (integ_acc_q >= $past(integ_min_q)))
    else $error("integrator outside its limits");

  // Loaded result stays inside ordered output limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_en[7] && valid_q[6] && (drive_min_q <= drive_max_q)
    |=> (drive_o <= $past(drive_max_q)) && (drive_o >= $past(drive_min_q)))
    else $error("drive outside its limits");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the pipelined PID controller with clamps and angle wrap.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcaw_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int Q1 = 65536;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint DEG180 = 64'sd180 * Q1;
  localparam longint DEG360 = 64'sd360 * Q1;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_SAMPLES = 125;

  typedef logic [DW-1:0] word_t;
  typedef word_t reg_file_t [8];

  localparam word_t W_MAX = 32'h7FFF_FFFF;
  localparam word_t W_MIN = 32'h8000_0000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [DW-1:0] target_i;
  logic signed [DW-1:0] sensed_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [DW-1:0] drive_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DW-1:0] cfg_data_i;

  // Controller settings and state as the predictor sees them
  longint kp = 0, ki = 0, kd = 0;
  longint integ_lo = SAT_LO, integ_hi = SAT_HI;
  longint drive_lo = SAT_LO, drive_hi = SAT_HI;
  bit angle_on = 1'b0;
  longint integ_model = 0, prev_error = 0, prev_sensed = 0;

  logic signed [DW-1:0] pending_drive_q [$];
  int mismatch_count = 0;
  int samples_sent = 0;
  int drives_checked = 0;
  int writes_done = 0;
  int in_idle_pct = 0;
  int stall_pct = 0;
  bit hold_results_req = 1'b0;

  pid_controller_angle_wrap_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_i    (target_i),
    .sensed_i    (sensed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_word(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Full-width product, floor shift by the fraction bits, saturate
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return sat_word(p >>> FB);
  endfunction

  // Bring a value into range once by a single 360 degree step
  function automatic longint wrap_deg(longint v);
    if (v < -DEG180) v = sat_word(v + DEG360);
    if (v > DEG180) v = sat_word(v - DEG360);
    return v;
  endfunction

  // Upper bound tested first: with reversed limits a value above hi gives hi, any other gives lo
  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint pid_next_drive(longint tgt, longint snd);
    longint err, prop, deriv;
    if (angle_on) tgt = wrap_deg(tgt);
    err = sat_word(tgt - snd);
    if (angle_on) err = wrap_deg(err);
    prop = fx_mul(kp, err);
    integ_model = sat_word(integ_model + fx_mul(ki, sat_word(err + prev_error)));
    integ_model = clamp_to(integ_model, integ_lo, integ_hi);
    deriv = sat_word(-fx_mul(kd, sat_word(snd - prev_sensed)));
    prev_error = err;
    prev_sensed = snd;
    return clamp_to(sat_word(prop + integ_model + deriv), drive_lo, drive_hi);
  endfunction

  // ----------------------------------------------------------------- scoreboard

  // Check results first, then track register writes and new requests
  always @(posedge clk_i) begin : scoreboard
    logic signed [DW-1:0] want;
    longint v;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_drive_q.size() == 0) begin
          $display("%0t: drive %0d arrived with no request pending", $time, drive_o);
          mismatch_count++;
        end else begin
          want = pending_drive_q.pop_front();
          drives_checked++;
          if (drive_o !== want) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d", $time, want, drive_o);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        v = longint'($signed(cfg_data_i));
        writes_done++;
        case (cfg_reg_e'(cfg_index_i))
          CFG_GAIN_P:        kp = v;
          CFG_GAIN_I_SCALED: ki = v;
          CFG_GAIN_D:        kd = v;
          CFG_INTEG_MIN:     integ_lo = v;
          CFG_INTEG_MAX:     integ_hi = v;
          CFG_DRIVE_MIN:     drive_lo = v;
          CFG_DRIVE_MAX:     drive_hi = v;
          CFG_ANGLE_MODE:    angle_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        pending_drive_q.push_back(DW'(pid_next_drive(longint'(target_i), longint'(sensed_i))));
        samples_sent++;
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_results_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run when no channel has moved a request for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------- drivers

  // Offer one request after a random idle gap; return at the falling edge after it is taken
  task automatic send_sample(input word_t tgt, input word_t snd);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i <= tgt;
    sensed_i <= snd;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every pending drive value is back and the pipe is empty
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk_i);
    repeat (NUM_STAGES + 2) @(negedge clk_i);
  endtask

  // Write all eight registers in index order
  task automatic load_settings(input reg_file_t regs);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i <= regs[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
  endtask

  function automatic reg_file_t make_settings(word_t p, word_t i, word_t d, word_t ilo,
                                              word_t ihi, word_t dlo, word_t dhi, word_t ang);
    reg_file_t regs;
    regs[CFG_GAIN_P] = p;
    regs[CFG_GAIN_I_SCALED] = i;
    regs[CFG_GAIN_D] = d;
    regs[CFG_INTEG_MIN] = ilo;
    regs[CFG_INTEG_MAX] = ihi;
    regs[CFG_DRIVE_MIN] = dlo;
    regs[CFG_DRIVE_MAX] = dhi;
    regs[CFG_ANGLE_MODE] = ang;
    return regs;
  endfunction

  // Mix of full-range words, angles within two turns, near-extremes and small values
  function automatic word_t rand_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return word_t'(int'($urandom_range(0, 1440 * Q1)) - 720 * Q1);
      2: begin
        case ($urandom_range(2))
          0: return W_MAX - $urandom_range(3);
          1: return W_MIN + $urandom_range(3);
          default: return word_t'(int'($urandom_range(0, 4)) - 2);
        endcase
      end
      default: return word_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
    endcase
  endfunction

  function automatic word_t rand_gain();
    if ($urandom_range(3) == 0) return $urandom();
    return word_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
  endfunction

  // Full range, ordered, reversed or narrow symmetric limits
  function automatic void pick_limits(output word_t lo, output word_t hi);
    logic signed [DW-1:0] a, b;
    a = rand_word();
    b = rand_word();
    case ($urandom_range(3))
      0: begin
        lo = W_MIN;
        hi = W_MAX;
      end
      1: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      2: begin
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      default: begin
        a = $urandom_range(1, 32'h0100_0000);
        lo = -a;
        hi = a;
      end
    endcase
  endfunction

  function automatic reg_file_t rand_settings(bit extreme_gains);
    reg_file_t regs;
    if (extreme_gains) begin
      regs[CFG_GAIN_P] = $urandom_range(1) ? W_MAX : W_MIN;
      regs[CFG_GAIN_I_SCALED] = $urandom_range(1) ? W_MAX : W_MIN;
      regs[CFG_GAIN_D] = $urandom_range(1) ? W_MAX : W_MIN;
    end else begin
      regs[CFG_GAIN_P] = rand_gain();
      regs[CFG_GAIN_I_SCALED] = rand_gain();
      regs[CFG_GAIN_D] = rand_gain();
    end
    pick_limits(regs[CFG_INTEG_MIN], regs[CFG_INTEG_MAX]);
    pick_limits(regs[CFG_DRIVE_MIN], regs[CFG_DRIVE_MAX]);
    regs[CFG_ANGLE_MODE] = $urandom();
    return regs;
  endfunction

  // ---------------------------------------------------------------------- tests

  // Zero gains straight out of reset give a zero drive whatever the inputs
  task automatic test_reset_defaults();
    wait_results_done();
    send_sample(W_MAX, W_MIN);
    send_sample(W_MIN, W_MAX);
    send_sample(word_t'(12345), word_t'(-678));
  endtask

  // Field extremes, floor rounding of negative products, sum saturation
  task automatic test_gain_extremes();
    word_t tgts [6] = '{W_MAX, W_MIN, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0};
    word_t snds [6] = '{W_MIN, W_MAX, 32'h0, 32'h0, 32'h0, W_MAX};
    wait_results_done();
    load_settings(make_settings(32'h0001_8000, 32'h0000_8000, 32'hFFFE_0000,
                                W_MIN, W_MAX, W_MIN, W_MAX, 32'h0));
    foreach (tgts[n]) send_sample(tgts[n], snds[n]);
  endtask

  // Reversed integrator and output limits with extreme gains
  task automatic test_reversed_limits();
    word_t tgts [4] = '{W_MAX, 32'h0, W_MIN, word_t'(123456)};
    word_t snds [4] = '{32'h0, W_MAX, W_MIN, word_t'(-654321)};
    wait_results_done();
    load_settings(make_settings(W_MAX, W_MIN, W_MIN, 32'h0001_0000, 32'hFFFF_0000,
                                word_t'(100 * Q1), word_t'(-100 * Q1), 32'h0));
    foreach (tgts[n]) send_sample(tgts[n], snds[n]);
  endtask

  // Setpoint wrap both ways, exact half turns, saturating wrap, error wrap
  task automatic test_angle_wrap();
    word_t tgts [11] = '{word_t'(181 * Q1), word_t'(-181 * Q1), word_t'(180 * Q1),
                         word_t'(-180 * Q1), word_t'(540 * Q1), word_t'(-540 * Q1),
                         word_t'(170 * Q1), word_t'(-170 * Q1), 32'h0, W_MAX, W_MIN};
    word_t snds [11] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                         word_t'(-170 * Q1), word_t'(170 * Q1), W_MIN, 32'h0, 32'h0};
    wait_results_done();
    // only bit 0 of the mode register counts; upper bits are set to show they are ignored
    load_settings(make_settings(32'h0001_0000, 32'h0000_1000, 32'h0,
                                W_MIN, W_MAX, W_MIN, W_MAX, 32'hFFFF_FFFF));
    foreach (tgts[n]) send_sample(tgts[n], snds[n]);
  endtask

  // Hold results off long enough to fill the pipe and stall the input side
  task automatic test_result_backpressure();
    wait_results_done();
    load_settings(make_settings(32'h0002_0000, 32'h0000_0800, 32'h0000_4000,
                                W_MIN, W_MAX, 32'hFF00_0000, 32'h0100_0000, 32'h0));
    in_idle_pct = 0;
    stall_pct = 0;
    hold_results_req = 1'b1;
    for (int n = 0; n < 30; n++) send_sample(rand_word(), rand_word());
    // pause until every held result is back, then resume under stalls
    wait_results_done();
    stall_pct = 67;
    for (int n = 0; n < 10; n++) send_sample(rand_word(), rand_word());
  endtask

  // Random settings per phase; mostly a measurement tracking a held setpoint, some noise
  task automatic test_random_settings();
    logic signed [DW-1:0] setpt, meas;
    longint next_meas;
    setpt = 0;
    meas = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_results_done();
      load_settings(rand_settings(phase == RANDOM_PHASES - 1));
      case (phase % 4)
        0: begin
          in_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          in_idle_pct = 67;
          stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          stall_pct = 67;
        end
        default: begin
          in_idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(9) < 7) begin
          if ($urandom_range(15) == 0) setpt = rand_word();
          next_meas = longint'(meas) + ((longint'(setpt) - longint'(meas)) >>> 2) +
                      longint'(int'($urandom_range(0, 2048)) - 1024);
          meas = next_meas[DW-1:0];
          send_sample(setpt, meas);
        end else begin
          send_sample(rand_word(), rand_word());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    target_i = '0;
    sensed_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GAIN_P;
    cfg_data_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_gain_extremes();
    test_reversed_limits();
    test_angle_wrap();
    test_result_backpressure();
    test_random_settings();
    wait_results_done();

    if (pending_drive_q.size() != 0) begin
      $display("%0t: %0d drive values never arrived", $time, pending_drive_q.size());
      mismatch_count++;
    end
    $display("summary: %0d samples, %0d drive values checked, %0d register writes",
             samples_sent, drives_checked, writes_done);
    $display("summary: wrap, clamp and saturation cases, random settings, idle and hold-off");
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
